// ===== rtl/core/hctv_pkg.sv =====
// ----------------------------------------------------------------------------
// hctv_pkg
// Types, character codes and helpers shared by the map-value token checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hctv_pkg;

  localparam int unsigned MAX_DIGITS = 10;

  // parse phase codes
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_X      = 3'd4;
  localparam logic [2:0] PH_HEX    = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [2:0] HEX_MAX = 3'd6;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } hctv_in_t;

  typedef struct packed {
    logic       valid_res;
    logic [4:0] value_length;
    logic       has_color;
  } hctv_out_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [3:0] digit_count;
    logic [2:0] hex_count;
    logic [4:0] position;
    logic       decided;
    logic       verdict;
    logic       color_seen;
  } hctv_state_t;

  localparam hctv_state_t STATE_RESET = '{
    phase:       PH_START,
    digit_count: 4'd0,
    hex_count:   3'd0,
    position:    5'd0,
    decided:     1'b0,
    verdict:     1'b0,
    color_seen:  1'b0
  };

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // verdict when the value ends in the given phase
  function automatic logic end_ok(input logic [2:0] phase, input logic [2:0] hex_count);
    logic ok;
    ok = 1'b0;
    if (phase == PH_DIGITS) begin
      ok = 1'b1;
    end else if (phase == PH_HEX) begin
      ok = (hex_count == 3'd6) || (hex_count == 3'd4) ||
           (hex_count == 3'd3) || (hex_count == 3'd2);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hctv_step.sv =====
// ----------------------------------------------------------------------------
// hctv_step
// One-byte parse step: next parser state and the result for a last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hctv_step (
  input  hctv_pkg::hctv_state_t st,
  input  hctv_pkg::hctv_in_t    item,
  output hctv_pkg::hctv_state_t st_next,
  output hctv_pkg::hctv_out_t   res
);

  hctv_pkg::hctv_state_t s;
  logic                  ok;
  logic [7:0]            c;

  assign c = item.ch;

  always_comb begin
    s = st;
    if (!st.decided) begin
      if ((c == hctv_pkg::CH_NUL) || (c == hctv_pkg::CH_SPACE) || (c == hctv_pkg::CH_NL)) begin
        s.decided = 1'b1;
        s.verdict = hctv_pkg::end_ok(st.phase, st.hex_count);
      end else begin
        unique case (st.phase)
          hctv_pkg::PH_START: begin
            if ((c == hctv_pkg::CH_MINUS) || (c == hctv_pkg::CH_PLUS)) begin
              s.phase    = hctv_pkg::PH_SIGNED;
              s.position = st.position + 5'd1;
            end else if (hctv_pkg::is_dec(c)) begin
              s.phase       = hctv_pkg::PH_DIGITS;
              s.digit_count = 4'd1;
              s.position    = st.position + 5'd1;
            end else begin
              s.decided = 1'b1;
              s.verdict = 1'b0;
            end
          end
          hctv_pkg::PH_SIGNED: begin
            if (hctv_pkg::is_dec(c)) begin
              s.phase       = hctv_pkg::PH_DIGITS;
              s.digit_count = 4'd1;
              s.position    = st.position + 5'd1;
            end else begin
              s.decided = 1'b1;
              s.verdict = 1'b0;
            end
          end
          hctv_pkg::PH_DIGITS: begin
            if (hctv_pkg::is_dec(c) &&
                (st.digit_count < 4'(hctv_pkg::MAX_DIGITS))) begin
              s.digit_count = st.digit_count + 4'd1;
              s.position    = st.position + 5'd1;
            end else if (c == hctv_pkg::CH_COMMA) begin
              s.phase      = hctv_pkg::PH_ZERO;
              s.color_seen = 1'b1;
              s.position   = st.position + 5'd1;
            end else begin
              s.decided = 1'b1;
              s.verdict = 1'b0;
            end
          end
          hctv_pkg::PH_ZERO: begin
            if (c == hctv_pkg::CH_ZERO) begin
              s.phase    = hctv_pkg::PH_X;
              s.position = st.position + 5'd1;
            end else begin
              s.decided = 1'b1;
              s.verdict = 1'b0;
            end
          end
          hctv_pkg::PH_X: begin
            if (c == hctv_pkg::CH_LX) begin
              s.phase    = hctv_pkg::PH_HEX;
              s.position = st.position + 5'd1;
            end else begin
              s.decided = 1'b1;
              s.verdict = 1'b0;
            end
          end
          hctv_pkg::PH_HEX: begin
            if (hctv_pkg::is_hex(c) && (st.hex_count < hctv_pkg::HEX_MAX)) begin
              s.hex_count = st.hex_count + 3'd1;
              s.position  = st.position + 5'd1;
            end else begin
              s.decided = 1'b1;
              s.verdict = 1'b0;
            end
          end
          default: begin
            s.decided = 1'b1;
            s.verdict = 1'b0;
          end
        endcase
      end
    end
  end

  // end of item without a terminator closes the value where it stands
  assign ok = s.decided ? s.verdict : hctv_pkg::end_ok(s.phase, s.hex_count);

  assign res.valid_res    = ok;
  assign res.value_length = ok ? s.position : 5'd0;
  assign res.has_color    = ok & s.color_seen;

  assign st_next = item.last ? hctv_pkg::STATE_RESET : s;

endmodule

`default_nettype wire

// ===== rtl/core/height_color_token_validator.sv =====
// ----------------------------------------------------------------------------
// height_color_token_validator
// Checks a byte stream against the map-value format and reports the verdict
// and value length on the byte marked last.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  item     | item_valid, item_ready | item (ch, last), one byte per item
//  res      | res_valid, res_ready   | res (valid_res, value_length, has_color)
//
//  One byte per cycle sustained unless a stalled result holds a last byte;
//  each byte passes the input register and its parse step runs into the
//  state and result registers; the result register loads on a last byte.
//  A stalled result only holds back a last byte; other bytes keep flowing.
//  Synchronous reset returns the parser to the start of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module height_color_token_validator (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  hctv_pkg::hctv_in_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output hctv_pkg::hctv_out_t res
);

  hctv_pkg::hctv_in_t    item_buf;
  logic                  item_buf_valid;
  hctv_pkg::hctv_state_t st;
  hctv_pkg::hctv_state_t st_next;
  hctv_pkg::hctv_out_t   res_next;
  logic                  res_free;
  logic                  consume;

  assign res_free   = !res_valid || res_ready;
  assign consume    = item_buf_valid && (!item_buf.last || res_free);
  assign item_ready = !item_buf_valid || consume;

  hctv_step u_step (
    .st      (st),
    .item    (item_buf),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_buf_valid <= 1'b0;
      st             <= hctv_pkg::STATE_RESET;
      res_valid      <= 1'b0;
    end else begin
      if (item_ready) begin
        item_buf_valid <= item_valid;
      end
      if (consume) begin
        st <= st_next;
      end
      if (consume && item_buf.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_buf <= item;
    end
    if (consume && item_buf.last) begin
      res <= res_next;
    end
  end

  // an invalid verdict carries no length and no color
  a_invalid_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.valid_res) |-> (res.value_length == 5'd0 && !res.has_color))
    else $error("invalid result with nonzero fields");

  // shortest colored value is one digit, comma, 0x and two hex digits
  a_color_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.has_color) |-> (res.value_length >= 5'd6))
    else $error("color suffix with too short a value");

  // parser is back at string start after a last byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (consume && item_buf.last) |=> (st.phase == hctv_pkg::PH_START &&
                                    st.position == 5'd0 && !st.decided))
    else $error("parser not reset after last byte");

  // a buffered byte is never dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (item_buf_valid && !consume) |=> (item_buf_valid && $stable(item_buf)))
    else $error("buffered byte lost");

endmodule

`default_nettype wire
